// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on a rising edge and disabled
// while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic check with a fixed failure message.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");

// Same check with a caller-supplied message.
`define ASSERT_CLK_MSG(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

`endif

// ===== rtl/rgbh_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbh_pkg
// Types, constants and helper functions for the RGB histogram accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbh_pkg;

	localparam int LEVELS      = 256;
	localparam int COUNT_WIDTH = 32;
	localparam int LVL_W       = $clog2(LEVELS);
	localparam int CH_W        = 8;
	localparam int OUT_W       = 32;

	typedef logic [CH_W-1:0]        chan_t;
	typedef logic [LVL_W-1:0]       addr_t;
	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [OUT_W-1:0]       out_cnt_t;

	typedef enum logic {
		ST_IDLE,
		ST_RMW
	} state_t;

	typedef enum logic {
		KIND_PIXEL = 1'b0,
		KIND_READ  = 1'b1
	} kind_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
	} rd_req_t;

	typedef struct packed {
		logic   en;
		addr_t  addr;
		count_t data;
	} wr_req_t;

	// Value names a bin that may be counted or read.
	function automatic logic bin_ok(chan_t v, chan_t max_lvl);
		return (v <= max_lvl) && (32'(v) < 32'(LEVELS));
	endfunction

	// Saturating increment.
	function automatic count_t sat_inc(count_t c);
		return (c == '1) ? c : c + count_t'(1);
	endfunction

	// Clamp a count to the output field width.
	function automatic out_cnt_t report(count_t c);
		logic [63:0] w;
		w = 64'(c);
		return (w > 64'h0000_0000_FFFF_FFFF) ? '1 : w[OUT_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/rgbh_bin_store.sv =====
// ----------------------------------------------------------------------------
// rgbh_bin_store
// One bank of histogram counters: synchronous RAM with a registered read,
// plus per-entry valid bits so never-written bins read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbh_bin_store (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rgbh_pkg::rd_req_t rd,
	input  wire rgbh_pkg::wr_req_t wr,
	output rgbh_pkg::count_t       rd_data
);

	rgbh_pkg::count_t               mem [rgbh_pkg::LEVELS];
	logic [rgbh_pkg::LEVELS-1:0]    valid_q;
	rgbh_pkg::count_t               data_s1;
	logic                           hit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			data_s1 <= mem[rd.addr];
			hit_s1  <= valid_q[rd.addr];
		end
	end

	assign rd_data = hit_s1 ? data_s1 : '0;

endmodule

`default_nettype wire

// ===== rtl/rgb_histogram_accumulator.sv =====
// ----------------------------------------------------------------------------
// rgb_histogram_accumulator
// Three-channel 8-bit color histogram with saturating counters and a bin
// read-back command.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  command   kind red green blue bin                 start, busy
//  result    count_red count_green count_blue        done (one-cycle strobe)
//            out_of_range
//  config    cfg_data (max_level)                    cfg_we
//
//  Each command does the synchronous bin RAM read in its accepting cycle, then
//  the increment and write-back in ST_RMW, with busy high. The result strobe
//  follows in the cycle after ST_RMW, and a new command may start then.
//  After reset all bins read as zero at once (per-entry valid bits, no
//  clearing pass). The result side has no back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_histogram_accumulator (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic                kind,
	input  wire rgbh_pkg::chan_t     red,
	input  wire rgbh_pkg::chan_t     green,
	input  wire rgbh_pkg::chan_t     blue,
	input  wire rgbh_pkg::chan_t     bin,
	input  wire logic                cfg_we,
	input  wire rgbh_pkg::chan_t     cfg_data,
	output logic                     done,
	output rgbh_pkg::out_cnt_t       count_red,
	output rgbh_pkg::out_cnt_t       count_green,
	output rgbh_pkg::out_cnt_t       count_blue,
	output logic                     out_of_range
);

	rgbh_pkg::state_t   state_q, state_d;
	rgbh_pkg::chan_t    max_level_q;
	logic               accept;

	rgbh_pkg::chan_t    sel_r, sel_g, sel_b;
	logic               is_read;

	logic               kind_s1;
	logic               ok_r_s1, ok_g_s1, ok_b_s1;
	rgbh_pkg::addr_t    addr_r_s1, addr_g_s1, addr_b_s1;

	rgbh_pkg::rd_req_t  rd_r, rd_g, rd_b;
	rgbh_pkg::wr_req_t  wr_r, wr_g, wr_b;
	rgbh_pkg::count_t   cnt_r, cnt_g, cnt_b;
	logic               wb;

	logic               done_q;
	rgbh_pkg::out_cnt_t count_red_q, count_green_q, count_blue_q;
	logic               oor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_level_q <= 8'hFF;
		end else if (cfg_we) begin
			max_level_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rgbh_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b0;
		accept  = 1'b0;
		wb      = 1'b0;
		unique case (state_q)
			rgbh_pkg::ST_IDLE: begin
				accept = start;
				if (start) begin
					state_d = rgbh_pkg::ST_RMW;
				end
			end
			rgbh_pkg::ST_RMW: begin
				busy    = 1'b1;
				wb      = 1'b1;
				state_d = rgbh_pkg::ST_IDLE;
			end
			default: begin
				state_d = rgbh_pkg::ST_IDLE;
			end
		endcase
	end

	// a read command addresses the same bin in all three banks
	assign is_read = (kind == rgbh_pkg::KIND_READ);
	assign sel_r   = is_read ? bin : red;
	assign sel_g   = is_read ? bin : green;
	assign sel_b   = is_read ? bin : blue;

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= kind;
			ok_r_s1   <= rgbh_pkg::bin_ok(sel_r, max_level_q);
			ok_g_s1   <= rgbh_pkg::bin_ok(sel_g, max_level_q);
			ok_b_s1   <= rgbh_pkg::bin_ok(sel_b, max_level_q);
			addr_r_s1 <= rgbh_pkg::LVL_W'(sel_r);
			addr_g_s1 <= rgbh_pkg::LVL_W'(sel_g);
			addr_b_s1 <= rgbh_pkg::LVL_W'(sel_b);
		end
	end

	assign rd_r = '{en: accept, addr: rgbh_pkg::LVL_W'(sel_r)};
	assign rd_g = '{en: accept, addr: rgbh_pkg::LVL_W'(sel_g)};
	assign rd_b = '{en: accept, addr: rgbh_pkg::LVL_W'(sel_b)};

	// out-of-range channels are skipped; the others still count
	assign wr_r = '{en: wb && !kind_s1 && ok_r_s1, addr: addr_r_s1,
		data: rgbh_pkg::sat_inc(cnt_r)};
	assign wr_g = '{en: wb && !kind_s1 && ok_g_s1, addr: addr_g_s1,
		data: rgbh_pkg::sat_inc(cnt_g)};
	assign wr_b = '{en: wb && !kind_s1 && ok_b_s1, addr: addr_b_s1,
		data: rgbh_pkg::sat_inc(cnt_b)};

	rgbh_bin_store u_store_r (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (rd_r),
		.wr      (wr_r),
		.rd_data (cnt_r)
	);

	rgbh_bin_store u_store_g (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (rd_g),
		.wr      (wr_g),
		.rd_data (cnt_g)
	);

	rgbh_bin_store u_store_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (rd_b),
		.wr      (wr_b),
		.rd_data (cnt_b)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= wb;
		end
	end

	always_ff @(posedge clk) begin
		if (wb) begin
			count_red_q   <= (kind_s1 && ok_r_s1) ? rgbh_pkg::report(cnt_r) : '0;
			count_green_q <= (kind_s1 && ok_g_s1) ? rgbh_pkg::report(cnt_g) : '0;
			count_blue_q  <= (kind_s1 && ok_b_s1) ? rgbh_pkg::report(cnt_b) : '0;
			oor_q         <= !(ok_r_s1 && ok_g_s1 && ok_b_s1);
		end
	end

	assign done         = done_q;
	assign count_red    = count_red_q;
	assign count_green  = count_green_q;
	assign count_blue   = count_blue_q;
	assign out_of_range = oor_q;

endmodule

`default_nettype wire

// ===== rtl/rgbh_checker.sv =====
// ----------------------------------------------------------------------------
// rgbh_checker
// Port-level checks on command/result timing and zero counts of the histogram accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rgbh_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                start,
	input wire logic                busy,
	input wire logic                kind,
	input wire logic                done,
	input wire rgbh_pkg::out_cnt_t  count_red,
	input wire rgbh_pkg::out_cnt_t  count_green,
	input wire rgbh_pkg::out_cnt_t  count_blue,
	input wire logic                out_of_range
);

	logic counts_zero;

	assign counts_zero = (count_red == '0) && (count_green == '0) && (count_blue == '0);

	`ASSERT_CLK(a_start_busy, clk, arst_n, (start && !busy) |=> busy)

	`ASSERT_CLK(a_busy_one_cycle, clk, arst_n, busy |=> (!busy && done))

	`ASSERT_CLK_MSG(a_done_after_busy, clk, arst_n, done |-> $past(busy), "stray result strobe")

	`ASSERT_CLK_MSG(a_oor_zero, clk, arst_n, (done && out_of_range) |-> counts_zero, "count on oor")

	`ASSERT_CLK(a_pixel_zero, clk, arst_n, (start && !busy && !kind) |-> ##2 (done && counts_zero))

endmodule

bind rgb_histogram_accumulator rgbh_checker u_rgbh_checker (.*);

`default_nettype wire

// ===== tb/tb_rgb_histogram_accumulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_histogram_accumulator
// Self-checking bench for the RGB histogram: a queue-fed command driver, a
// result monitor compared against an in-bench model of the three bin stores,
// directed corner cases, then random phases under several max_level values.
// ----------------------------------------------------------------------------

module tb_rgb_histogram_accumulator;
	import rgbh_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int IDLE_PCT    = 28;
	localparam int PHASE_CMDS  = 215;

	typedef struct {
		kind_t kind;
		chan_t red;
		chan_t green;
		chan_t blue;
		chan_t bin;
	} hist_cmd_t;

	typedef struct {
		out_cnt_t red;
		out_cnt_t green;
		out_cnt_t blue;
		logic     oor;
	} bin_counts_t;

	logic     clk      = 1'b0;
	logic     arst_n   = 1'b0;
	logic     start    = 1'b0;
	logic     kind     = 1'b0;
	chan_t    red      = '0;
	chan_t    green    = '0;
	chan_t    blue     = '0;
	chan_t    bin      = '0;
	logic     cfg_we   = 1'b0;
	chan_t    cfg_data = '0;
	logic     busy;
	logic     done;
	out_cnt_t count_red;
	out_cnt_t count_green;
	out_cnt_t count_blue;
	logic     out_of_range;

	rgb_histogram_accumulator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.bin          (bin),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.done         (done),
		.count_red    (count_red),
		.count_green  (count_green),
		.count_blue   (count_blue),
		.out_of_range (out_of_range)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// model state
	count_t      hist [3][LEVELS];
	chan_t       max_lvl = 8'd255;

	hist_cmd_t   cmd_queue [$];
	bin_counts_t counts_due [$];
	hist_cmd_t   cmd_on_bus;
	bin_counts_t want;
	chan_t       recent [8];
	int          recent_ix = 0;
	bit          no_gaps = 1'b0;

	int n_pushed = 0;
	int n_done   = 0;
	int n_err    = 0;
	int n_pix    = 0;
	int n_rd     = 0;
	int n_oor    = 0;
	int n_cfg    = 0;
	int stall    = 0;

	function automatic bit lvl_counted(chan_t v);
		return (v <= max_lvl) && (int'(v) < LEVELS);
	endfunction

	function automatic out_cnt_t clamp_count(count_t c);
		return (64'(c) > 64'h0000_0000_FFFF_FFFF) ? '1 : out_cnt_t'(c);
	endfunction

	// Applies one command to the model and returns the counts it produces.
	function automatic bin_counts_t histogram_step(hist_cmd_t cmd);
		chan_t       v [3];
		bin_counts_t res;
		v = '{cmd.red, cmd.green, cmd.blue};
		res = '{default: '0};
		if (cmd.kind == KIND_PIXEL) begin
			n_pix++;
			for (int c = 0; c < 3; c++) begin
				if (lvl_counted(v[c])) begin
					if (hist[c][v[c]] != '1)
						hist[c][v[c]] = hist[c][v[c]] + count_t'(1);
				end else begin
					res.oor = 1'b1;
				end
			end
		end else begin
			n_rd++;
			if (lvl_counted(cmd.bin)) begin
				res.red   = clamp_count(hist[0][cmd.bin]);
				res.green = clamp_count(hist[1][cmd.bin]);
				res.blue  = clamp_count(hist[2][cmd.bin]);
			end else begin
				res.oor = 1'b1;
			end
		end
		if (res.oor)
			n_oor++;
		return res;
	endfunction

	task automatic flag_mismatch(string what, longint got, longint exp_val);
		$display("ERROR @%0t result %0d: %s got %0d want %0d", $realtime, n_done, what,
			got, exp_val);
		n_err++;
	endtask

	// Driver: start held until accepted, random gaps inserted between transactions unless no_gaps is set.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				counts_due.push_back(histogram_step(cmd_on_bus));
			if (!start || !busy) begin
				if (cmd_queue.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
					cmd_on_bus = cmd_queue.pop_front();
					start <= 1'b1;
					kind  <= cmd_on_bus.kind;
					red   <= cmd_on_bus.red;
					green <= cmd_on_bus.green;
					blue  <= cmd_on_bus.blue;
					bin   <= cmd_on_bus.bin;
				end else begin
					start <= 1'b0;
					kind  <= 1'($urandom);
					red   <= 8'($urandom);
					green <= 8'($urandom);
					blue  <= 8'($urandom);
					bin   <= 8'($urandom);
				end
			end
		end
	end

	// Monitor: one-cycle done strobe, no back-pressure.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (counts_due.size() == 0) begin
				flag_mismatch("result with nothing pending, count_red", count_red, 0);
			end else begin
				want = counts_due.pop_front();
				if (count_red !== want.red)
					flag_mismatch("count_red", count_red, want.red);
				if (count_green !== want.green)
					flag_mismatch("count_green", count_green, want.green);
				if (count_blue !== want.blue)
					flag_mismatch("count_blue", count_blue, want.blue);
				if (out_of_range !== want.oor)
					flag_mismatch("out_of_range", out_of_range, want.oor);
				n_done++;
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall <= 0;
		else
			stall <= stall + 1;
		if (stall >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("tb_rgb_histogram_accumulator NOT OK");
			$finish;
		end
	end

	task automatic push_cmd(kind_t k, chan_t r, chan_t g, chan_t b, chan_t bn);
		cmd_queue.push_back('{kind: k, red: r, green: g, blue: b, bin: bn});
		n_pushed++;
		if (k == KIND_PIXEL) begin
			recent[recent_ix] = r;
			recent[(recent_ix + 1) % 8] = g;
			recent[(recent_ix + 2) % 8] = b;
			recent_ix = (recent_ix + 3) % 8;
		end
	endtask

	task automatic wait_idle();
		while (n_done != n_pushed)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_max(chan_t v);
		wait_idle();
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		max_lvl = v;
		cfg_we   <= 1'b0;
		cfg_data <= 8'($urandom);
		n_cfg++;
	endtask

	// Channel values biased toward reused bins, the max_level boundary and the extremes 0 and 255.
	function automatic chan_t pick_level();
		int p;
		p = $urandom_range(99);
		if (p < 30)
			return recent[$urandom_range(7)];
		if (p < 45)
			return chan_t'(max_lvl + $urandom_range(2) - 1);
		if (p < 52)
			return ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
		return 8'($urandom);
	endfunction

	task automatic gen_random(int n);
		hist_cmd_t last;
		last = '{kind: KIND_PIXEL, red: 8'($urandom), green: 8'($urandom),
			blue: 8'($urandom), bin: 8'($urandom)};
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 62) begin
				// repeat of the previous pixel stresses back-to-back same-bin updates
				if ($urandom_range(99) >= 20) begin
					last.red   = pick_level();
					last.green = pick_level();
					last.blue  = pick_level();
				end
				push_cmd(KIND_PIXEL, last.red, last.green, last.blue, 8'($urandom));
			end else begin
				push_cmd(KIND_READ, 8'($urandom), 8'($urandom), 8'($urandom), pick_level());
			end
		end
	endtask

	initial begin
		chan_t phase_lvl [6];
		for (int c = 0; c < 3; c++)
			for (int i = 0; i < LEVELS; i++)
				hist[c][i] = '0;
		for (int i = 0; i < 8; i++)
			recent[i] = 8'($urandom);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset default max_level: empty bins, extremes, same bins back to back
		push_cmd(KIND_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'd0);
		push_cmd(KIND_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'd255);
		push_cmd(KIND_PIXEL, 8'd0, 8'd0, 8'd0, 8'($urandom));
		push_cmd(KIND_PIXEL, 8'd255, 8'd255, 8'd255, 8'($urandom));
		push_cmd(KIND_PIXEL, 8'd255, 8'd0, 8'd128, 8'($urandom));
		repeat (3) push_cmd(KIND_PIXEL, 8'd7, 8'd7, 8'd7, 8'($urandom));
		push_cmd(KIND_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'd7);
		push_cmd(KIND_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'd0);
		push_cmd(KIND_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'd255);
		push_cmd(KIND_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'd128);

		// one channel over the limit still counts the others
		write_max(8'd100);
		push_cmd(KIND_PIXEL, 8'd101, 8'd50, 8'd100, 8'($urandom));
		push_cmd(KIND_PIXEL, 8'd100, 8'd101, 8'd255, 8'($urandom));
		push_cmd(KIND_PIXEL, 8'd200, 8'd200, 8'd200, 8'($urandom));
		push_cmd(KIND_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'd100);
		push_cmd(KIND_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'd101);
		push_cmd(KIND_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'd255);
		push_cmd(KIND_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'd50);

		write_max(8'd0);
		push_cmd(KIND_PIXEL, 8'd0, 8'd1, 8'd0, 8'($urandom));
		push_cmd(KIND_PIXEL, 8'd1, 8'd0, 8'd255, 8'($urandom));
		push_cmd(KIND_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'd0);
		push_cmd(KIND_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'd1);

		phase_lvl = '{8'd255, 8'($urandom_range(1, 254)), 8'd0, 8'd128,
			8'($urandom), 8'd255};
		for (int ph = 0; ph < 6; ph++) begin
			write_max(phase_lvl[ph]);
			no_gaps = (ph == 3);
			gen_random(PHASE_CMDS);
		end
		wait_idle();
		no_gaps = 1'b0;

		if (counts_due.size() != 0)
			flag_mismatch("results never returned", 0, counts_due.size());
		$display("covered %0d pixel and %0d read transactions, %0d flagged out of range",
			n_pix, n_rd, n_oor);
		$display("%0d max_level writes, %0d mismatches", n_cfg, n_err);
		if (n_err == 0)
			$display("tb_rgb_histogram_accumulator OK");
		else
			$display("tb_rgb_histogram_accumulator NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rgbh_pkg.sv
rtl/rgbh_bin_store.sv
rtl/rgb_histogram_accumulator.sv
rtl/rgbh_checker.sv
tb/tb_rgb_histogram_accumulator.sv
